[hdl/icfps_pkg.sv]
// ============================================================================
// icfps_pkg - shared types and tables for the isometric cube face scatter
// Beat layouts, face codes, shading factors and the per-face offset tables.
// ============================================================================
package icfps_pkg;

    // Face select codes
    typedef enum logic [1:0] {
        FACE_TOP   = 2'd0,
        FACE_LEFT  = 2'd1,
        FACE_RIGHT = 2'd2
    } face_t;

    // Face select code with no face behind it
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // Default upper bound on the face edge
    localparam int MAX_SIZE_DEF = 64;

    // Register reset value (raw log2 of the face edge)
    localparam logic [2:0] SIZE_LOG2_RST = 3'd4;
    localparam logic [2:0] SIZE_LOG2_MIN = 3'd2;
    localparam logic [2:0] SIZE_LOG2_MAX = 3'd6;

    // Shading factors in Q0.16
    localparam logic [15:0] SHADE_LEFT  = 16'd54831;
    localparam logic [15:0] SHADE_RIGHT = 16'd43962;

    // Index of the final write of each face
    localparam logic [4:0] TOP_LAST  = 5'd15;
    localparam logic [4:0] SIDE_LAST = 5'd19;

    // Field widths
    localparam int COORD_W = 6;
    localparam int SIZE_W  = 7;
    localparam int X_W     = 9;
    localparam int Y_W     = 10;
    localparam int POS_W   = 10;
    localparam int ADDR_W  = 19;

    // Input beat
    typedef struct packed {
        logic [1:0]         func;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        logic [31:0]        pixel;
    } texel_t;

    // Result beat
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [31:0]       color;
        logic              last;
    } wr_t;

    // Shaded texel with its face origin
    typedef struct packed {
        face_t          face;
        logic [31:0]    color;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } item_t;

    // One target position before address generation
    typedef struct packed {
        logic [POS_W-1:0] xx;
        logic [POS_W-1:0] yy;
        logic [31:0]      color;
        logic             last;
    } spot_t;

    // Offset pair
    typedef struct packed {
        logic [2:0] ox;
        logic [2:0] oy;
    } off_t;

    localparam logic [2:0] TOP_OX [16] = '{
        3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3,
        3'd4, 3'd5, 3'd6, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5
    };
    localparam logic [2:0] TOP_OY [16] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2
    };
    localparam logic [2:0] LEFT_OX [20] = '{
        3'd0, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3, 3'd2, 3'd3
    };
    localparam logic [2:0] RIGHT_OX [20] = '{
        3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1
    };
    localparam logic [2:0] SIDE_OY [20] = '{
        3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5
    };

    // Look up offset number k of a face
    function automatic off_t off_lookup(face_t f, logic [4:0] k);
        off_t o;
        o.ox = 3'd0;
        o.oy = 3'd0;
        unique case (f)
            FACE_TOP:
            begin
                o.ox = TOP_OX[k[3:0]];
                o.oy = TOP_OY[k[3:0]];
            end
            FACE_LEFT:
            begin
                o.ox = LEFT_OX[k];
                o.oy = SIDE_OY[k];
            end
            FACE_RIGHT:
            begin
                o.ox = RIGHT_OX[k];
                o.oy = SIDE_OY[k];
            end
            default:
            begin
                o.ox = 3'd0;
                o.oy = 3'd0;
            end
        endcase
        return o;
    endfunction

    // Index of the final write for a face
    function automatic logic [4:0] last_index(face_t f);
        return (f == FACE_TOP) ? TOP_LAST : SIDE_LAST;
    endfunction

    // Clamp a raw log2 edge to the legal range and to the largest edge allowed
    function automatic logic [2:0] eff_log2(logic [2:0] raw, logic [2:0] max_log2);
        logic [2:0] l;
        l = raw;
        if (l < SIZE_LOG2_MIN) l = SIZE_LOG2_MIN;
        if (l > SIZE_LOG2_MAX) l = SIZE_LOG2_MAX;
        if (l > max_log2) l = max_log2;
        if (l < SIZE_LOG2_MIN) l = SIZE_LOG2_MIN;
        return l;
    endfunction

    // Scale one color byte by a Q0.16 factor, truncating
    function automatic logic [7:0] shade_byte(logic [7:0] c, logic [15:0] b);
        logic [23:0] p;
        p = 24'(c) * 24'(b);
        return p[23:16];
    endfunction

endpackage

[hdl/icfps_prep.sv]
// ============================================================================
// icfps_prep - input register, shading and face origin
// Stage 1 masks and registers the texel, stage 2 shades side-face texels
// and works out the isometric origin of the face position.
// ============================================================================
module icfps_prep
    import icfps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [2:0]   size_log2,
    input  logic         texel_valid,
    output logic         texel_ready,
    input  texel_t       texel,
    output logic         item_valid,
    input  logic         item_ready,
    output item_t        item
);

    logic               s1_valid_reg, s1_valid_next;
    texel_t             s1_reg, s1_next;
    logic               s2_valid_reg, s2_valid_next;
    item_t              s2_reg, s2_next;
    logic               s2_free;
    logic               s1_move;
    logic               take;
    logic [SIZE_W-1:0]  size;
    logic [COORD_W-1:0] mask;
    logic [7:0]         top_t;
    logic [SIZE_W-1:0]  right_t;
    logic [15:0]        shade_f;

    assign size = SIZE_W'(1) << size_log2;
    assign mask = COORD_W'(size - SIZE_W'(1));

    // Handshake between the stages
    assign s2_free     = !s2_valid_reg || item_ready;
    assign s1_move     = s1_valid_reg && s2_free;
    assign texel_ready = !s1_valid_reg || s2_free;
    assign take        = texel_valid && texel_ready;

    // Stage 1: mask the position, drop beats with no face
    always_comb
    begin
        s1_next       = s1_reg;
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = (texel.func != FUNC_NONE);
            s1_next.func  = texel.func;
            s1_next.u     = texel.u & mask;
            s1_next.v     = texel.v & mask;
            s1_next.pixel = texel.pixel;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Stage 2: shade side-face colors and place the face origin
    assign top_t   = 8'(s1_reg.u) + 8'(size) - 8'd1 - 8'(s1_reg.v);
    assign right_t = SIZE_W'(s1_reg.u) + size;
    assign shade_f = (s1_reg.func == FACE_LEFT) ? SHADE_LEFT : SHADE_RIGHT;

    always_comb
    begin
        s2_next       = s2_reg;
        s2_valid_next = s2_valid_reg;
        if (s1_move)
        begin
            s2_valid_next = 1'b1;
            s2_next.face  = face_t'(s1_reg.func);
            if (s1_reg.func == FACE_TOP)
            begin
                s2_next.color = s1_reg.pixel;
            end
            else
            begin
                s2_next.color = {s1_reg.pixel[31:24],
                                 shade_byte(s1_reg.pixel[23:16], shade_f),
                                 shade_byte(s1_reg.pixel[15:8], shade_f),
                                 shade_byte(s1_reg.pixel[7:0], shade_f)};
            end
            unique case (s1_reg.func)
                FACE_TOP:
                begin
                    s2_next.x = {top_t[6:0], 2'b00};
                    s2_next.y = (Y_W'(s1_reg.u) + Y_W'(s1_reg.v)) << 1;
                end
                FACE_LEFT:
                begin
                    s2_next.x = {1'b0, s1_reg.u, 2'b00};
                    s2_next.y = (Y_W'(s1_reg.u) << 1) + (Y_W'(s1_reg.v) << 2)
                              + Y_W'(s1_reg.v) + (Y_W'(size) << 1);
                end
                default:
                begin
                    s2_next.x = {right_t, 2'b00};
                    s2_next.y = (Y_W'(s1_reg.v) << 2) + Y_W'(s1_reg.v)
                              + (Y_W'(size) << 2) - Y_W'(2) - (Y_W'(s1_reg.u) << 1);
                end
            endcase
        end
        else if (item_ready)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_reg;

    // A beat with no face never reaches stage 1
    a_drop_none: assert property (@(posedge clk) disable iff (!rst_n)
        (take && texel.func == FUNC_NONE) |=> !s1_valid_reg)
        else $error("beat with no face entered the pipeline");

endmodule

[hdl/icfps_expand.sv]
// ============================================================================
// icfps_expand - offset sequencer
// Holds one shaded texel and steps through its face's offset table, one target
// position per cycle into a registered position stage, unless that stage stalls.
// ============================================================================
module icfps_expand
    import icfps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    output logic  spot_valid,
    input  logic  spot_ready,
    output spot_t spot
);

    logic       hold_valid_reg, hold_valid_next;
    item_t      hold_reg, hold_next;
    logic [4:0] k_reg, k_next;
    logic       spot_valid_reg, spot_valid_next;
    spot_t      spot_reg, spot_next;
    logic       s4_free;
    logic       emit;
    logic       k_last;
    off_t       off;

    assign s4_free    = !spot_valid_reg || spot_ready;
    assign emit       = hold_valid_reg && s4_free;
    assign k_last     = (k_reg == last_index(hold_reg.face));
    assign item_ready = !hold_valid_reg || (emit && k_last);
    assign off        = off_lookup(hold_reg.face, k_reg);

    // Hold the texel and advance the offset counter
    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        k_next          = k_reg;
        if (item_valid && item_ready)
        begin
            hold_next       = item;
            hold_valid_next = 1'b1;
            k_next          = 5'd0;
        end
        else if (emit && k_last)
        begin
            hold_valid_next = 1'b0;
        end
        else if (emit)
        begin
            k_next = k_reg + 5'd1;
        end
    end

    // Register one target position
    always_comb
    begin
        spot_next       = spot_reg;
        spot_valid_next = spot_valid_reg;
        if (emit)
        begin
            spot_valid_next = 1'b1;
            spot_next.xx    = POS_W'(hold_reg.x) + POS_W'(off.ox);
            spot_next.yy    = POS_W'(hold_reg.y) + POS_W'(off.oy);
            spot_next.color = hold_reg.color;
            spot_next.last  = k_last;
        end
        else if (spot_ready)
        begin
            spot_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            spot_valid_reg <= 1'b0;
            k_reg          <= 5'd0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            spot_valid_reg <= spot_valid_next;
            k_reg          <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        spot_reg <= spot_next;
    end

    assign spot_valid = spot_valid_reg;
    assign spot       = spot_reg;

    // Counter stays within the face's table
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (k_reg <= last_index(hold_reg.face)))
        else $error("offset counter past end of table");

    // Final offset goes out marked last
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && k_last) |=> (spot_valid_reg && spot_reg.last))
        else $error("final write not marked last");

    // A stalled sequencer does not skip offsets
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !emit) |=> $stable(k_reg))
        else $error("offset counter moved during stall");

endmodule

[hdl/icfps_addr.sv]
// ============================================================================
// icfps_addr - linear address generation and output register
// Turns a target position into its index in the cube image and holds the
// finished write until it is taken.
// ============================================================================
module icfps_addr
    import icfps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [2:0] size_log2,
    input  logic       spot_valid,
    output logic       spot_ready,
    input  spot_t      spot,
    output logic       wr_valid,
    input  logic       wr_ready,
    output wr_t        wr
);

    logic              wr_valid_reg, wr_valid_next;
    wr_t               wr_reg, wr_next;
    logic [SIZE_W-1:0] size;
    logic [POS_W-1:0]  cube;
    logic [19:0]       row_base;
    logic              take;

    assign size       = SIZE_W'(1) << size_log2;
    assign cube       = (POS_W'(size) << 3) + POS_W'(size);
    assign spot_ready = !wr_valid_reg || wr_ready;
    assign take       = spot_valid && spot_ready;
    assign row_base   = 20'(spot.yy) * 20'(cube);

    // Build the write beat
    always_comb
    begin
        wr_next       = wr_reg;
        wr_valid_next = wr_valid_reg;
        if (take)
        begin
            wr_valid_next  = 1'b1;
            wr_next.address = ADDR_W'(row_base + 20'(spot.xx) + 20'(size >> 1));
            wr_next.color   = spot.color;
            wr_next.last    = spot.last;
        end
        else if (wr_ready)
        begin
            wr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            wr_valid_reg <= wr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_reg <= wr_next;
    end

    assign wr_valid = wr_valid_reg;
    assign wr       = wr_reg;

endmodule

[hdl/iso_cube_face_pixel_scatter_top.sv]
// ============================================================================
// iso_cube_face_pixel_scatter_top - isometric cube face texel scatter
// Shades side-face texels and writes each face texel to its offset positions
// in the cube image.
//
//   channel   dir  handshake              payload
//   texel     in   texel_valid/ready      texel_t: func, u, v, pixel
//   wr        out  wr_valid/ready         wr_t: address, color, last
//   cfg       in   cfg_valid/ready        cfg_size_log2 (always ready)
//
// Five register stages: input, shade/origin, offset sequencer, position,
// address/output. A texel makes 16 writes (top face) or 20 writes (side
// face), one write per cycle out of the offset sequencer unless wr stalls.
// A face select of 3 is accepted and dropped. Reset clears all valid bits
// and sets size_log2 to 4, clamped to MAX_SIZE. A stall on wr backs up
// stage by stage; nothing is lost or repeated.
// ============================================================================
module iso_cube_face_pixel_scatter_top
    import icfps_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_size_log2,
    input  logic       texel_valid,
    output logic       texel_ready,
    input  texel_t     texel,
    output logic       wr_valid,
    input  logic       wr_ready,
    output wr_t        wr
);

    localparam int MAX_LOG2 = $clog2(MAX_SIZE + 1) - 1;

    logic [2:0] size_log2_reg, size_log2_next;
    logic       item_valid, item_ready;
    item_t      item;
    logic       spot_valid, spot_ready;
    spot_t      spot;

    // Configuration register, stored already clamped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        size_log2_next = size_log2_reg;
        if (cfg_valid && cfg_ready)
        begin
            size_log2_next = eff_log2(cfg_size_log2, 3'(MAX_LOG2));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= eff_log2(SIZE_LOG2_RST, 3'(MAX_LOG2));
        end
        else
        begin
            size_log2_reg <= size_log2_next;
        end
    end

    icfps_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .size_log2   (size_log2_reg),
        .texel_valid (texel_valid),
        .texel_ready (texel_ready),
        .texel       (texel),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item)
    );

    icfps_expand u_expand (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .spot_valid (spot_valid),
        .spot_ready (spot_ready),
        .spot       (spot)
    );

    icfps_addr u_addr (
        .clk        (clk),
        .rst_n      (rst_n),
        .size_log2  (size_log2_reg),
        .spot_valid (spot_valid),
        .spot_ready (spot_ready),
        .spot       (spot),
        .wr_valid   (wr_valid),
        .wr_ready   (wr_ready),
        .wr         (wr)
    );

endmodule

[test/iso_cube_face_pixel_scatter_top_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// iso_cube_face_pixel_scatter_top_test - self-checking bench for the scatter
// Sends face texels and compares every write beat with a local model.
// The model shades the texel and computes each offset address in the cube
// image at the current face size. The size register is swept through every
// code, including the codes below and above the legal range. Both channels
// stall in random bursts, and the last part of the run has no stalls.
// ============================================================================
module iso_cube_face_pixel_scatter_top_test;
    import icfps_pkg::*;

    localparam int MAX_EDGE      = 64;
    localparam int STALL_LIMIT   = 1000;
    localparam int PIPE_SETTLE   = 10;
    localparam int LEFT_FACTOR   = 54831;
    localparam int RIGHT_FACTOR  = 43962;

    // Offset pairs of each face, in write order
    localparam int TOP_DX [16] = '{2, 3, 4, 5, 0, 1, 2, 3, 4, 5, 6, 7, 2, 3, 4, 5};
    localparam int TOP_DY [16] = '{0, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 2, 2, 2, 2};
    localparam int LEFT_DX [20] = '{0, 1, 0, 1, 2, 3, 0, 1, 2, 3,
                                    0, 1, 2, 3, 0, 1, 2, 3, 2, 3};
    localparam int RIGHT_DX [20] = '{2, 3, 0, 1, 2, 3, 0, 1, 2, 3,
                                     0, 1, 2, 3, 0, 1, 2, 3, 0, 1};
    localparam int SIDE_DY [20] = '{0, 0, 1, 1, 1, 1, 2, 2, 2, 2,
                                    3, 3, 3, 3, 4, 4, 4, 4, 5, 5};

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_size_log2;
    logic       texel_valid;
    logic       texel_ready;
    texel_t     texel;
    logic       wr_valid;
    logic       wr_ready = 1'b0;
    wr_t        wr;

    wr_t        pending_writes [$];
    wr_t        exp_w;
    logic [2:0] size_log2_q;
    int         errors;
    int         idle_cycles;
    int         hold_cnt;
    bit         calm;

    iso_cube_face_pixel_scatter_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_size_log2 (cfg_size_log2),
        .texel_valid   (texel_valid),
        .texel_ready   (texel_ready),
        .texel         (texel),
        .wr_valid      (wr_valid),
        .wr_ready      (wr_ready),
        .wr            (wr)
    );

    // Free-running clock, 2 ns period
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Shade R, G and B by a Q0.16 factor, keep alpha
    function automatic logic [31:0] shade_rgb(logic [31:0] px, int factor);
        logic [31:0] res;
        res = px;
        for (int i = 0; i < 3; i++)
            res[8*i +: 8] = 8'((int'(px[8*i +: 8]) * factor) >> 16);
        return res;
    endfunction

    // Queue the writes one texel causes at the current face size
    function automatic void predict_writes(texel_t t);
        int          l;
        int          edge_len;
        int          uu;
        int          vv;
        int          x;
        int          y;
        int          n;
        int          dx;
        int          dy;
        logic [31:0] col;
        wr_t         w;
        l = int'(size_log2_q);
        if (l < 2) l = 2;
        if (l > 6) l = 6;
        while (l > 2 && (1 << l) > MAX_EDGE) l--;
        edge_len = 1 << l;
        uu = int'(t.u) & (edge_len - 1);
        vv = int'(t.v) & (edge_len - 1);
        case (t.func)
            FACE_TOP:
            begin
                col = t.pixel;
                x = 4 * uu - 4 * vv + 4 * (edge_len - 1);
                y = 2 * uu + 2 * vv;
                n = 16;
            end
            FACE_LEFT:
            begin
                col = shade_rgb(t.pixel, LEFT_FACTOR);
                x = 4 * uu;
                y = 2 * uu + 5 * vv + 2 * edge_len;
                n = 20;
            end
            FACE_RIGHT:
            begin
                col = shade_rgb(t.pixel, RIGHT_FACTOR);
                x = 4 * uu + 4 * edge_len;
                y = -2 * uu + 5 * vv + 4 * edge_len - 2;
                n = 20;
            end
            default:
            begin
                // no face behind this code: dropped
                return;
            end
        endcase
        for (int k = 0; k < n; k++)
        begin
            if (t.func == FACE_TOP)
            begin
                dx = TOP_DX[k];
                dy = TOP_DY[k];
            end
            else
            begin
                dx = (t.func == FACE_LEFT) ? LEFT_DX[k] : RIGHT_DX[k];
                dy = SIDE_DY[k];
            end
            w.address = ADDR_W'((y + dy) * 9 * edge_len + x + dx + edge_len / 2);
            w.color   = col;
            w.last    = (k == n - 1);
            pending_writes.push_back(w);
        end
    endfunction

    // Track config, predict on texel beats, check write beats, watch for hangs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                size_log2_q = cfg_size_log2;
            if (texel_valid && texel_ready)
                predict_writes(texel);
            if (wr_valid && wr_ready)
            begin
                if (pending_writes.size() == 0)
                begin
                    $display("%0t: write beat with nothing expected: address %0d color %h last %b",
                             $time, wr.address, wr.color, wr.last);
                    errors++;
                end
                else
                begin
                    exp_w = pending_writes.pop_front();
                    if (wr.address !== exp_w.address)
                    begin
                        $display("%0t: address expected %0d, actual %0d",
                                 $time, exp_w.address, wr.address);
                        errors++;
                    end
                    if (wr.color !== exp_w.color)
                    begin
                        $display("%0t: color expected %h, actual %h",
                                 $time, exp_w.color, wr.color);
                        errors++;
                    end
                    if (wr.last !== exp_w.last)
                    begin
                        $display("%0t: last expected %b, actual %b",
                                 $time, exp_w.last, wr.last);
                        errors++;
                    end
                end
            end
            if ((cfg_valid && cfg_ready) || (texel_valid && texel_ready)
                || (wr_valid && wr_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("iso_cube_face_pixel_scatter_top_test: errors");
                $finish;
            end
        end
    end

    // Stall the write channel in random bursts unless the run is calm
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            wr_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            hold_cnt = $urandom_range(1, 12) - 1;
            wr_ready <= 1'b0;
        end
        else
        begin
            wr_ready <= 1'b1;
        end
    end

    // Send one texel beat, maybe after a random gap; entered at a falling edge
    task automatic send_texel(logic [1:0] f, logic [5:0] uu, logic [5:0] vv,
                              logic [31:0] px);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            texel_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        texel_valid = 1'b1;
        texel.func  = f;
        texel.u     = uu;
        texel.v     = vv;
        texel.pixel = px;
        @(posedge clk);
        while (!texel_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_texel();
        logic [1:0] f;
        f = ($urandom_range(0, 9) == 0) ? FUNC_NONE : 2'($urandom_range(0, 2));
        send_texel(f, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), $urandom);
    endtask

    // Hold the sender until every expected write is out and the pipe is empty
    task automatic wait_drained();
        texel_valid = 1'b0;
        while (pending_writes.size() != 0) @(negedge clk);
        repeat (PIPE_SETTLE) @(negedge clk);
    endtask

    task automatic write_size(logic [2:0] val);
        wait_drained();
        cfg_valid     = 1'b1;
        cfg_size_log2 = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Corners, byte extremes and the dropped code at the reset size
    task automatic test_directed();
        for (int f = 0; f < 3; f++)
        begin
            send_texel(2'(f), 6'd0,  6'd0,  32'h0000_0000);
            send_texel(2'(f), 6'd15, 6'd15, 32'hFFFF_FFFF);
            send_texel(2'(f), 6'd0,  6'd15, 32'h80FF_7F01);
            send_texel(2'(f), 6'd15, 6'd0,  32'h00FF_00FF);
            send_texel(2'(f), 6'd63, 6'd63, 32'hA5A5_5A5A);
        end
        send_texel(FUNC_NONE, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_texel(FACE_LEFT, 6'd42, 6'd21, 32'h5A5A_A5A5);
        send_texel(FUNC_NONE, 6'd0,  6'd0,  32'h0000_0000);
    endtask

    // Every register code, in and out of range, with random texels
    task automatic test_size_sweep();
        logic [2:0] plan [8] = '{3'd2, 3'd6, 3'd0, 3'd7, 3'd3, 3'd5, 3'd1, 3'd4};
        foreach (plan[i])
        begin
            write_size(plan[i]);
            for (int f = 0; f < 3; f++)
                send_texel(2'(f), 6'd63, 6'd63, $urandom);
            repeat (52) send_random_texel();
        end
    endtask

    // Full rate on both sides to the end
    task automatic test_calm_tail();
        write_size(3'd6);
        calm = 1'b1;
        repeat (40) send_random_texel();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_size_log2 = SIZE_LOG2_RST;
        texel_valid   = 1'b0;
        texel         = '0;
        size_log2_q   = SIZE_LOG2_RST;
        errors        = 0;
        idle_cycles   = 0;
        hold_cnt      = 0;
        calm          = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_size_sweep();
        test_calm_tail();

        // drain, then let the pipe settle
        wait_drained();
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("iso_cube_face_pixel_scatter_top_test: clean");
        else
            $display("iso_cube_face_pixel_scatter_top_test: errors");
        $finish;
    end

endmodule

[files.f]
hdl/icfps_pkg.sv
hdl/icfps_prep.sv
hdl/icfps_expand.sv
hdl/icfps_addr.sv
hdl/iso_cube_face_pixel_scatter_top.sv
test/iso_cube_face_pixel_scatter_top_test.sv
